@@ src/mtt_pkg.sv @@
package mtt_pkg;

  typedef enum logic [2:0] {
    MODE_FIRST     = 3'd0,
    MODE_TAG_NAME  = 3'd1,
    MODE_BETWEEN   = 3'd2,
    MODE_ATTR_NAME = 3'd3,
    MODE_AFTER_EQ  = 3'd4,
    MODE_QUOTED    = 3'd5,
    MODE_UNQUOTED  = 3'd6
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_END   = 2'd1,
    KIND_SELF  = 2'd2
  } tag_kind_t;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_TAG   = 2'd1,
    ROLE_ATTR  = 2'd2,
    ROLE_VALUE = 2'd3
  } char_role_t;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;

  typedef struct packed {
    scan_mode_t mode;
    tag_kind_t  kind;
  } scan_state_t;

  typedef struct packed {
    char_role_t role;
    logic       attr_done;
    logic       tag_done;
    tag_kind_t  kind;
  } scan_out_t;

  // Digits, letters and _ - , .
  function automatic logic is_word(input logic [7:0] c);
    logic w;
    w = (c >= 8'h30 && c <= 8'h39) ||
        (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A) ||
        c == CH_UNDER || c == CH_DASH || c == CH_COMMA || c == CH_PERIOD;
    return w;
  endfunction

endpackage

@@ src/mtt_scan.sv @@
module mtt_scan
  import mtt_pkg::*;
(
  input  logic [7:0]  ch,
  input  logic        new_tag,
  input  logic        buffer_end,
  input  scan_state_t cur,
  output scan_state_t nxt,
  output scan_out_t   res
);

  scan_mode_t mode;
  tag_kind_t  kind;
  char_role_t role;
  logic       attr_done;
  logic       closed;
  logic       word;

  assign word = is_word(ch);

  always_comb begin
    mode      = new_tag ? MODE_FIRST : cur.mode;
    kind      = new_tag ? KIND_BEGIN : cur.kind;
    role      = ROLE_NONE;
    attr_done = 1'b0;
    closed    = 1'b0;
    unique case (mode)
      MODE_TAG_NAME: begin
        if (ch == CH_GT) closed = 1'b1;
        else if (word) role = ROLE_TAG;
        else mode = MODE_BETWEEN;
      end
      MODE_BETWEEN: begin
        if (ch == CH_GT) closed = 1'b1;
        else if (word) begin
          role = ROLE_ATTR;
          mode = MODE_ATTR_NAME;
        end else if (ch == CH_SLASH) kind = KIND_SELF;
      end
      MODE_ATTR_NAME: begin
        if (ch == CH_EQ) mode = MODE_AFTER_EQ;
        else if (word) role = ROLE_ATTR;
      end
      MODE_AFTER_EQ: begin
        if (ch == CH_QUOTE) mode = MODE_QUOTED;
        else if (word) begin
          role = ROLE_VALUE;
          mode = MODE_UNQUOTED;
        end
      end
      MODE_QUOTED: begin
        if (ch == CH_QUOTE) begin
          mode      = MODE_BETWEEN;
          attr_done = 1'b1;
        end else if (word) role = ROLE_VALUE;
      end
      MODE_UNQUOTED: begin
        if (ch == CH_NL || ch == CH_SPACE) begin
          mode      = MODE_BETWEEN;
          attr_done = 1'b1;
        end else if (word) role = ROLE_VALUE;
        else if (ch == CH_SLASH) kind = KIND_SELF;
        else if (ch == CH_GT) begin
          attr_done = 1'b1;
          closed    = 1'b1;
        end
      end
      default: begin
        // first byte, and the unused mode code
        if (ch == CH_SLASH) kind = KIND_END;
        else begin
          role = ROLE_TAG;
          mode = MODE_TAG_NAME;
        end
      end
    endcase

    res.role      = role;
    res.attr_done = attr_done;
    res.tag_done  = closed || buffer_end;
    res.kind      = kind;

    // Return to the reset state once the tag has ended
    if (closed || buffer_end) begin
      nxt.mode = MODE_FIRST;
      nxt.kind = KIND_BEGIN;
    end else begin
      nxt.mode = mode;
      nxt.kind = kind;
    end
  end

endmodule

@@ src/markup_tag_tokenizer.sv @@
// Markup tag tokenizer.
// Input stream (s_axis_*): one byte of tag text per request, starting with
// the byte after '<'. tuser raises new_tag to restart the scanner before
// the byte; tlast marks the last byte of a buffer, which ends the tag.
// Output stream (m_axis_*): one result per input byte, in order. tdata
// passes the byte through, tuser gives its role, an attribute-complete
// flag and the tag kind after the byte; tlast is set on the byte that
// ends the tag ('>' or end of buffer).
// Path: accepted byte into the input register, then the scan logic into
// the output register. Throughput: one byte per cycle while not stalled;
// the mode update is a single next-state function on each byte.
// Reset: both registers empty, scanner in its first mode, kind begin.
// Stall: while m_axis_tready is low the output holds; if the input register
// is empty, one more byte is taken into it, then s_axis_tready drops.
module markup_tag_tokenizer
  import mtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,
  input  logic       s_axis_tuser,   // [0] new_tag
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic [4:0] m_axis_tuser    // [1:0] char_role, [2] attribute_done, [4:3] tag_kind
);

  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_new;
  logic        in_last;
  logic        advance;
  scan_state_t state;
  scan_state_t state_next;
  scan_out_t   res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  mtt_scan u_scan (
    .ch         (in_char),
    .new_tag    (in_new),
    .buffer_end (in_last),
    .cur        (state),
    .nxt        (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state.mode    <= MODE_FIRST;
      state.kind    <= KIND_BEGIN;
    end else begin
      if (s_axis_tvalid && s_axis_tready) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        state         <= state_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_new  <= s_axis_tuser;
      in_last <= s_axis_tlast;
    end
    if (advance) begin
      m_axis_tdata <= in_char;
      m_axis_tlast <= res.tag_done;
      m_axis_tuser <= {res.kind, res.attr_done, res.role};
    end
  end

endmodule

@@ src/mtt_checker.sv @@
module mtt_checker
  import mtt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [4:0] m_axis_tuser
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A committing byte is a delimiter and never part of a name or value
  a_commit_ignored: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ROLE_NONE)
    else $error("attribute commit on a name or value byte");

  // Slash is never a name or value character
  a_slash_ignored: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata == CH_SLASH |-> m_axis_tuser[1:0] == ROLE_NONE)
    else $error("slash given a role");

  // A commit that also ends the tag sits on a value delimiter
  a_commit_close: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] && m_axis_tlast |->
      m_axis_tdata == CH_GT || m_axis_tdata == CH_SPACE ||
      m_axis_tdata == CH_NL || m_axis_tdata == CH_QUOTE)
    else $error("tag ended with commit on a non-delimiter");

endmodule

bind markup_tag_tokenizer mtt_checker u_mtt_checker (.*);
